@@ rtl/mbps_pkg.sv @@
// Package for the masked byte pattern search: sizes, register codes,
// configuration and item types. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mbps_pkg;

    localparam int MAX_PATTERN  = 24;
    localparam int ADDRESS_BITS = 48;

    localparam int REG_BYTES = 24;
    localparam int CMP_BYTES = (MAX_PATTERN < REG_BYTES) ? MAX_PATTERN : REG_BYTES;
    localparam int CFG_W     = 64;
    localparam int LEN_W     = 5;
    localparam int ADDR_W    = 48;
    localparam int IDX_W     = 3;
    localparam int WIN_IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

    localparam logic [ADDR_W-1:0] COUNT_MAX = '1;
    localparam logic [ADDR_W-1:0] ADDR_MASK = (ADDRESS_BITS >= ADDR_W) ? '1 :
        ADDR_W'((64'd1 << ADDRESS_BITS) - 64'd1);

    typedef enum logic [IDX_W-1:0] {
        REG_PATTERN_LOW  = 3'd0,
        REG_PATTERN_MID  = 3'd1,
        REG_PATTERN_HIGH = 3'd2,
        REG_MASK_LOW     = 3'd3,
        REG_MASK_MID     = 3'd4,
        REG_MASK_HIGH    = 3'd5,
        REG_LENGTH       = 3'd6,
        REG_BASE         = 3'd7
    } cfg_reg_t;

    typedef struct packed {
        logic [REG_BYTES-1:0][7:0] pattern;
        logic [REG_BYTES-1:0][7:0] mask;
        logic [LEN_W-1:0]          length;
        logic [ADDR_W-1:0]         base;
    } cfg_t;

    typedef logic [MAX_PATTERN-1:0][7:0] window_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last;
    } in_item_t;

    typedef struct packed {
        logic              found;
        logic [ADDR_W-1:0] match_address;
    } out_item_t;

endpackage

`default_nettype wire

@@ rtl/mbps_cfg_regs.sv @@
// Configuration register file of the masked byte pattern search.
// Depends on mbps_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mbps_cfg_regs
    import mbps_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_wr_en,
    input  wire logic [IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_PATTERN_LOW:  cfg_reg.pattern[7:0]   <= cfg_data;
                REG_PATTERN_MID:  cfg_reg.pattern[15:8]  <= cfg_data;
                REG_PATTERN_HIGH: cfg_reg.pattern[23:16] <= cfg_data;
                REG_MASK_LOW:     cfg_reg.mask[7:0]      <= cfg_data;
                REG_MASK_MID:     cfg_reg.mask[15:8]     <= cfg_data;
                REG_MASK_HIGH:    cfg_reg.mask[23:16]    <= cfg_data;
                REG_LENGTH:       cfg_reg.length         <= cfg_data[LEN_W-1:0];
                REG_BASE:         cfg_reg.base           <= cfg_data[ADDR_W-1:0];
                default:          cfg_reg                <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

@@ rtl/mbps_match.sv @@
// Parallel masked compare of the byte window against the pattern.
// Depends on mbps_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mbps_match
    import mbps_pkg::*;
(
    input  wire cfg_t               cfg,
    input  wire window_t            window,
    input  wire logic [ADDR_W-1:0]  seen,
    output logic                    hit
);

    logic                 len_ok;
    logic                 seen_ok;
    logic [CMP_BYTES-1:0] lane_ok;

    assign len_ok  = (cfg.length != '0) && (int'(cfg.length) <= CMP_BYTES);
    assign seen_ok = (seen >= ADDR_W'(cfg.length));

    // pattern byte j lines up with window entry length-1-j (newest first)
    always_comb
    begin
        for (int j = 0; j < CMP_BYTES; j++)
        begin
            logic [LEN_W:0]       diff;
            logic [WIN_IDX_W-1:0] idx;
            logic [7:0]           d;
            diff = {1'b0, cfg.length} - (LEN_W+1)'(j + 1);
            idx  = diff[WIN_IDX_W-1:0];
            d    = window[idx];
            if (j < int'(cfg.length))
                lane_ok[j] = ((d & cfg.mask[j]) == (cfg.pattern[j] & cfg.mask[j]));
            else
                lane_ok[j] = 1'b1;
        end
    end

    assign hit = len_ok && seen_ok && (&lane_ok);

endmodule

`default_nettype wire

@@ rtl/masked_byte_pattern_search.sv @@
// Top level of the masked byte pattern search: input register, window state,
// match stage and result register. Depends on mbps_pkg, mbps_cfg_regs, mbps_match.
`timescale 1ns / 1ps
`default_nettype none

// Takes one region byte per cycle and reports the first position where the
// last pattern_length bytes equal the pattern under the per-byte masks.
// One result per region at most: found with base_address plus the start
// offset, or not-found on the last byte. Sustained rate is one byte per
// cycle; while a result waits on out_ready the input is held off. A result
// is registered: the byte that causes it passes the input register, the
// single compare stage and the result register; a waiting result holds it
// back.
// Configuration may only be written while no item is in flight.
module masked_byte_pattern_search
    import mbps_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_wr_en,
    input  wire logic [IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0] cfg_data,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire in_item_t         in_data,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output out_item_t             out_data
);

    cfg_t cfg;

    mbps_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    logic              in_valid_reg;
    in_item_t          in_item_reg;
    window_t           window_reg,  window_next;
    logic [ADDR_W-1:0] seen_reg,    seen_next;
    logic              done_reg,    done_next;
    logic              out_valid_reg, out_valid_next;
    out_item_t         out_item_reg,  out_item_next;

    window_t           shifted;
    logic [ADDR_W-1:0] seen_inc;
    logic              hit;
    logic              process;
    logic              emit;

    assign process  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || process;

    always_comb
    begin
        shifted[0] = in_item_reg.data_byte;
        for (int i = 1; i < MAX_PATTERN; i++)
            shifted[i] = window_reg[i-1];
    end

    assign seen_inc = (seen_reg == COUNT_MAX) ? seen_reg : seen_reg + ADDR_W'(1);

    mbps_match u_match (
        .cfg    (cfg),
        .window (shifted),
        .seen   (seen_inc),
        .hit    (hit)
    );

    assign emit = !done_reg && (hit || in_item_reg.last);

    always_comb
    begin
        window_next = window_reg;
        seen_next   = seen_reg;
        done_next   = done_reg;
        if (process)
        begin
            if (in_item_reg.last)
            begin
                window_next = '0;
                seen_next   = '0;
                done_next   = 1'b0;
            end
            else if (!done_reg)
            begin
                window_next = shifted;
                seen_next   = seen_inc;
                done_next   = hit;
            end
        end
    end

    always_comb
    begin
        out_valid_next = (process && emit) || (out_valid_reg && !out_ready);
        out_item_next  = out_item_reg;
        if (process && emit)
        begin
            out_item_next.found = hit;
            if (hit)
                out_item_next.match_address =
                    (cfg.base + seen_inc - ADDR_W'(cfg.length)) & ADDR_MASK;
            else
                out_item_next.match_address = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            window_reg    <= '0;
            seen_reg      <= '0;
            done_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                in_valid_reg <= in_valid;
            window_reg    <= window_next;
            seen_reg      <= seen_next;
            done_reg      <= done_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            in_item_reg <= in_data;
        out_item_reg <= out_item_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_item_reg;

    a_hit_sets_done: assert property (@(posedge clk) disable iff (!rst_n)
        process && !done_reg && hit && !in_item_reg.last |=> done_reg)
        else $error("match did not close the region");

    a_done_holds_window: assert property (@(posedge clk) disable iff (!rst_n)
        process && done_reg && !in_item_reg.last |=> $stable(window_reg) && $stable(seen_reg))
        else $error("window moved after a match");

    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        process && in_item_reg.last |=> seen_reg == '0 && !done_reg)
        else $error("region state not cleared on last item");

    a_miss_zero_addr: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_item_reg.found |-> out_item_reg.match_address == '0)
        else $error("not-found result carries an address");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready |=> out_valid_reg && $stable(out_item_reg))
        else $error("stalled result changed");

endmodule

`default_nettype wire

@@ sim/mbps_scan_monitor.sv @@
// Scan monitor for the masked byte pattern search: tracks register writes, predicts
// the outcome of every accepted byte and compares it with each accepted result.
// Depends on mbps_pkg.
`timescale 1ns / 1ps

module mbps_scan_monitor
    import mbps_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_wr_en,
    input  logic [IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0] cfg_data,
    input  logic             in_valid,
    input  logic             in_ready,
    input  in_item_t         in_data,
    input  logic             out_valid,
    input  logic             out_ready,
    input  out_item_t        out_data,
    output int               fail_count,
    output int               outstanding
);

    cfg_t              shadow;
    window_t           recent;
    logic [ADDR_W-1:0] region_count;
    logic              region_hit;
    out_item_t         search_outcomes [$];

    function automatic void note_failure(input string what);
        fail_count++;
        if (fail_count <= 10)
        begin
            $display("%0t: %s", $time, what);
        end
    endfunction

    task automatic scan_byte(input in_item_t item);
        out_item_t outcome;
        int        n;
        int        k;
        logic      hit;
        if (!region_hit)
        begin
            recent = {recent[MAX_PATTERN-2:0], item.data_byte};
            if (region_count != '1)
            begin
                region_count++;
            end
            n   = int'(shadow.length);
            hit = (n != 0) && (n <= MAX_PATTERN) && (n <= REG_BYTES)
                  && (region_count >= ADDR_W'(n));
            for (k = 0; hit && k < n; k++)
            begin
                if ((recent[n-1-k] & shadow.mask[k]) != (shadow.pattern[k] & shadow.mask[k]))
                begin
                    hit = 1'b0;
                end
            end
            if (hit)
            begin
                outcome.found         = 1'b1;
                outcome.match_address = shadow.base + (region_count - ADDR_W'(n));
                search_outcomes = {search_outcomes, outcome};
                region_hit = 1'b1;
            end
            else if (item.last)
            begin
                outcome = '0;
                search_outcomes = {search_outcomes, outcome};
            end
        end
        if (item.last)
        begin
            recent       = '0;
            region_count = '0;
            region_hit   = 1'b0;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        out_item_t awaited;
        if (!rst_n)
        begin
            shadow       = '0;
            recent       = '0;
            region_count = '0;
            region_hit   = 1'b0;
            search_outcomes.delete();
            fail_count   = 0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_reg_t'(cfg_index))
                    REG_PATTERN_LOW:  shadow.pattern[7:0]   = cfg_data;
                    REG_PATTERN_MID:  shadow.pattern[15:8]  = cfg_data;
                    REG_PATTERN_HIGH: shadow.pattern[23:16] = cfg_data;
                    REG_MASK_LOW:     shadow.mask[7:0]      = cfg_data;
                    REG_MASK_MID:     shadow.mask[15:8]     = cfg_data;
                    REG_MASK_HIGH:    shadow.mask[23:16]    = cfg_data;
                    REG_LENGTH:       shadow.length         = cfg_data[LEN_W-1:0];
                    REG_BASE:         shadow.base           = cfg_data[ADDR_W-1:0];
                    default:          ;
                endcase
            end
            if (in_valid && in_ready)
            begin
                scan_byte(in_data);
            end
            if (out_valid && out_ready)
            begin
                if (search_outcomes.size() == 0)
                begin
                    note_failure($sformatf("unexpected result: found %0b addr %h",
                                           out_data.found, out_data.match_address));
                end
                else
                begin
                    awaited = search_outcomes.pop_front();
                    if (out_data.found !== awaited.found
                        || out_data.match_address !== awaited.match_address)
                    begin
                        note_failure($sformatf(
                            "mismatch: found %0b addr %h, wanted found %0b addr %h",
                            out_data.found, out_data.match_address,
                            awaited.found, awaited.match_address));
                    end
                end
            end
        end
        outstanding = search_outcomes.size();
    end

endmodule

@@ sim/tb.sv @@
// Testbench top for the masked byte pattern search: clock, reset, register loads,
// region stimulus under several idle mixes, and the verdict.
// Depends on mbps_pkg, masked_byte_pattern_search and mbps_scan_monitor.
`timescale 1ns / 1ps

module tb;
    import mbps_pkg::*;

    localparam int CYCLE_LIMIT  = 300000;
    localparam int PHASE_ITEMS  = 170;
    localparam int PHASE_COUNT  = 12;

    logic             clk;
    logic             rst_n;
    logic             cfg_wr_en;
    logic [IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0] cfg_data;
    logic             in_valid;
    logic             in_ready;
    in_item_t         in_data;
    logic             out_valid;
    logic             out_ready;
    out_item_t        out_data;

    int fail_count;
    int outstanding;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int cycles         = 0;

    logic [7:0] pat [REG_BYTES];
    logic [7:0] msk [REG_BYTES];
    int         pat_len;
    logic [7:0] region_bytes [$];

    masked_byte_pattern_search u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    mbps_scan_monitor u_scan_monitor (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic apply_settings(input int len, input logic [ADDR_W-1:0] base);
        logic [REG_BYTES-1:0][7:0] pw;
        logic [REG_BYTES-1:0][7:0] mw;
        cfg_reg_t                  r;
        int                        j;
        for (j = 0; j < REG_BYTES; j++)
        begin
            pw[j] = pat[j];
            mw[j] = msk[j];
        end
        pat_len = len;
        r = r.first();
        repeat (r.num())
        begin
            cfg_wr_en <= 1'b1;
            cfg_index <= r;
            case (r)
                REG_PATTERN_LOW:  cfg_data <= pw[7:0];
                REG_PATTERN_MID:  cfg_data <= pw[15:8];
                REG_PATTERN_HIGH: cfg_data <= pw[23:16];
                REG_MASK_LOW:     cfg_data <= mw[7:0];
                REG_MASK_MID:     cfg_data <= mw[15:8];
                REG_MASK_HIGH:    cfg_data <= mw[23:16];
                REG_LENGTH:       cfg_data <= {59'({$urandom, $urandom}), 5'(len)};
                default:          cfg_data <= {16'($urandom), base};
            endcase
            @(posedge clk);
            r = r.next();
        end
        cfg_wr_en <= 1'b0;
    endtask

    task automatic drive_item(input logic [7:0] value, input logic region_end);
        logic taken;
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
        end
        in_valid <= 1'b1;
        in_data  <= '{data_byte: value, last: region_end};
        do
        begin
            @(negedge clk);
            taken = in_ready;
            @(posedge clk);
        end
        while (!taken);
    endtask

    task automatic send_bytes();
        int i;
        for (i = 0; i < region_bytes.size(); i++)
        begin
            drive_item(region_bytes[i], i == region_bytes.size() - 1);
        end
    endtask

    // Pending results drained, then an idle wait for bytes that give no result.
    task automatic settle();
        int waited;
        waited = 0;
        in_valid <= 1'b0;
        do
        begin
            @(negedge clk);
            waited++;
        end
        while (outstanding != 0 && waited < 5000);
        @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic choose_settings(input int ph);
        int                len;
        int                mask_kind;
        int                j;
        logic [ADDR_W-1:0] base;
        base      = {16'($urandom), $urandom};
        mask_kind = 2;
        case (ph)
            0:
            begin
                len       = 1;
                mask_kind = 0;
                base      = '0;
            end
            1:
            begin
                len  = 24;
                base = '1;
            end
            2:       len = 0;
            3:
            begin
                len       = $urandom_range(25, 31);
                mask_kind = 0;
            end
            4:
            begin
                len       = $urandom_range(2, 6);
                mask_kind = 1;
                base      = '1 - ADDR_W'($urandom_range(3));
            end
            5:
            begin
                len       = 24;
                mask_kind = 0;
            end
            default: len = $urandom_range(1, 24);
        endcase
        for (j = 0; j < REG_BYTES; j++)
        begin
            pat[j] = 8'($urandom);
            case (mask_kind)
                0:       msk[j] = 8'hFF;
                1:       msk[j] = 8'h00;
                default:
                begin
                    case ($urandom_range(3))
                        0:       msk[j] = 8'hFF;
                        1:       msk[j] = 8'h00;
                        default: msk[j] = 8'($urandom);
                    endcase
                end
            endcase
        end
        apply_settings(len, base);
    endtask

    // Mostly regions that hold the pattern under its mask, some with one masked
    // bit broken, some ending on the match, the rest random bytes.
    task automatic send_random_region(inout int sent);
        int         kind;
        int         span;
        int         at;
        int         j;
        logic       plant;
        logic [7:0] flip;
        kind  = $urandom_range(99);
        plant = (pat_len >= 1) && (pat_len <= REG_BYTES) && (kind < 70);
        span  = $urandom_range(1, 24) + (plant ? pat_len : 0);
        if ($urandom_range(19) == 0)
        begin
            span += $urandom_range(40);
        end
        region_bytes.delete();
        for (j = 0; j < span; j++)
        begin
            region_bytes = {region_bytes, 8'($urandom)};
        end
        if (plant)
        begin
            at = (kind >= 10 && kind < 30) ? span - pat_len : $urandom_range(span - pat_len);
            for (j = 0; j < pat_len; j++)
            begin
                region_bytes[at+j] = (pat[j] & msk[j]) | (8'($urandom) & ~msk[j]);
            end
            if (kind < 10)
            begin
                j    = $urandom_range(pat_len - 1);
                flip = msk[j] & (~msk[j] + 8'd1);
                region_bytes[at+j] ^= flip;
            end
        end
        send_bytes();
        sent += span;
    endtask

    initial
    begin
        int ph;
        int sent;
        int j;
        rst_n     = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        in_valid  = 1'b0;
        in_data   = '0;
        out_ready = 1'b0;
        pat_len   = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero length after reset: no match, not-found on the last byte
        region_bytes = '{8'hA5, 8'h00, 8'hFF};
        send_bytes();
        settle();

        for (j = 0; j < REG_BYTES; j++)
        begin
            pat[j] = 8'($urandom);
            msk[j] = 8'hFF;
        end
        pat[0] = 8'hA5;
        pat[1] = 8'h00;
        pat[2] = 8'hFF;
        apply_settings(3, '1);
        region_bytes = '{8'hA5, 8'h00, 8'hFF};
        send_bytes();
        // match at offset one wraps the address; bytes after it are ignored
        region_bytes = '{8'h00, 8'hA5, 8'h00, 8'hFF, 8'h5A, 8'h11};
        send_bytes();
        region_bytes = '{8'hA5, 8'h00};
        send_bytes();
        region_bytes = '{8'hFF, 8'hA5, 8'h00, 8'hFE};
        send_bytes();
        settle();

        for (ph = 0; ph < PHASE_COUNT; ph++)
        begin
            choose_settings(ph);
            case (ph % 4)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 79;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 79;
                end
                default:
                begin
                    send_idle_pct  = 9;
                    recv_stall_pct = 9;
                end
            endcase
            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                send_random_region(sent);
            end
            settle();
        end

        if (outstanding != 0)
        begin
            $display("%0d results never arrived", outstanding);
        end
        if (fail_count == 0 && outstanding == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
